FILE: src/sltc_pkg.sv
// package for the script lexer token classifier: scanner states, token kinds, transition logic
`timescale 1ns / 1ps

package sltc_pkg;

  typedef enum logic [5:0] {
    ST_START  = 6'd0,
    ST_DOT    = 6'd1,
    ST_DDOT   = 6'd2,
    ST_LBR    = 6'd3,
    ST_RBR    = 6'd4,
    ST_LCB    = 6'd5,
    ST_RCB    = 6'd6,
    ST_SEMI   = 6'd7,
    ST_PLUS   = 6'd8,
    ST_COMMA  = 6'd9,
    ST_MUL    = 6'd10,
    ST_MINUS  = 6'd11,
    ST_QMARK  = 6'd12,
    ST_NUM    = 6'd13,
    ST_EXP0   = 6'd14,
    ST_EXP1   = 6'd15,
    ST_DEC0   = 6'd16,
    ST_DEC1   = 6'd17,
    ST_DIV    = 6'd18,
    ST_CSL    = 6'd19,
    ST_CML    = 6'd20,
    ST_CMLE   = 6'd21,
    ST_DOLLAR = 6'd22,
    ST_VAR    = 6'd23,
    ST_EXCL   = 6'd24,
    ST_NE0    = 6'd25,
    ST_NE1    = 6'd26,
    ST_ASSIGN = 6'd27,
    ST_EQ0    = 6'd28,
    ST_EQ1    = 6'd29,
    ST_IDENT  = 6'd30,
    ST_GT     = 6'd31,
    ST_GE     = 6'd32,
    ST_LT     = 6'd33,
    ST_LE     = 6'd34,
    ST_STR0   = 6'd35,
    ST_STR1   = 6'd36,
    ST_ESC0   = 6'd37,
    ST_ESC1   = 6'd38,
    ST_OCT    = 6'd39,
    ST_HEX0   = 6'd40,
    ST_HEX1   = 6'd41,
    ST_HEX2   = 6'd42,
    ST_TAG0   = 6'd43,
    ST_TAG1   = 6'd44,
    ST_TAG2   = 6'd45,
    ST_TAG3   = 6'd46,
    ST_TAG4   = 6'd47,
    ST_TAGEND = 6'd48,
    ST_FAIL   = 6'd63
  } scan_state_e;

  typedef enum logic [4:0] {
    KIND_ERROR     = 5'd0,
    KIND_END       = 5'd1,
    KIND_DOT       = 5'd2,
    KIND_COLON     = 5'd3,
    KIND_LPAREN    = 5'd4,
    KIND_RPAREN    = 5'd5,
    KIND_LBRACE    = 5'd6,
    KIND_RBRACE    = 5'd7,
    KIND_SEMI      = 5'd8,
    KIND_PLUS      = 5'd9,
    KIND_COMMA     = 5'd10,
    KIND_MUL       = 5'd11,
    KIND_MINUS     = 5'd12,
    KIND_INT       = 5'd13,
    KIND_DECIMAL   = 5'd14,
    KIND_EXPONENT  = 5'd15,
    KIND_DIV       = 5'd16,
    KIND_QMARK     = 5'd17,
    KIND_CLOSE_TAG = 5'd18,
    KIND_VAR       = 5'd19,
    KIND_NE        = 5'd20,
    KIND_EQ        = 5'd21,
    KIND_IDENT     = 5'd22,
    KIND_GT        = 5'd23,
    KIND_GE        = 5'd24,
    KIND_LT        = 5'd25,
    KIND_ASSIGN    = 5'd26,
    KIND_LE        = 5'd27,
    KIND_OPEN_TAG  = 5'd28,
    KIND_STRING    = 5'd29
  } token_kind_e;

  localparam int unsigned LenW = 12;

  typedef struct packed {
    token_kind_e      kind;
    logic [LenW-1:0]  len;
    logic             last;
  } token_t;

  function automatic logic is_space(logic [7:0] c);
    return (c inside {[8'd9:8'd13], 8'd32});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_quote(logic [7:0] c);
    return (c inside {"\"", 8'd39});
  endfunction

  function automatic logic is_strch(logic [7:0] c);
    return ((c > 8'd31) && (c != "$")) || is_space(c);
  endfunction

  function automatic scan_state_e advance(scan_state_e s, logic [7:0] c);
    scan_state_e r;
    r = ST_FAIL;
    case (s)
      ST_START: begin
        if (is_space(c)) r = ST_START;
        else if (is_alpha(c)) r = ST_IDENT;
        else if (is_digit(c)) r = ST_NUM;
        else if (is_quote(c)) r = ST_STR0;
        else begin
          case (c)
            "-":     r = ST_MINUS;
            "*":     r = ST_MUL;
            ",":     r = ST_COMMA;
            "+":     r = ST_PLUS;
            ";":     r = ST_SEMI;
            "}":     r = ST_RCB;
            "{":     r = ST_LCB;
            ")":     r = ST_RBR;
            "(":     r = ST_LBR;
            ".":     r = ST_DOT;
            "/":     r = ST_DIV;
            "?":     r = ST_QMARK;
            "$":     r = ST_DOLLAR;
            "!":     r = ST_EXCL;
            "=":     r = ST_ASSIGN;
            ">":     r = ST_GT;
            ":":     r = ST_DDOT;
            "<":     r = ST_LT;
            default: r = ST_FAIL;
          endcase
        end
      end
      ST_QMARK: r = (c == ">") ? ST_TAGEND : ST_FAIL;
      ST_NUM: begin
        if (is_digit(c)) r = ST_NUM;
        else if (c == ".") r = ST_DEC0;
        else if (c inside {"e", "E"}) r = ST_EXP0;
      end
      ST_EXP0, ST_EXP1: r = is_digit(c) ? ST_EXP1 : ST_FAIL;
      ST_DEC0: r = is_digit(c) ? ST_DEC1 : ST_FAIL;
      ST_DEC1: begin
        if (is_digit(c)) r = ST_DEC1;
        else if (c inside {"e", "E"}) r = ST_EXP0;
      end
      ST_DIV: begin
        if (c == "/") r = ST_CSL;
        else if (c == "*") r = ST_CML;
      end
      ST_CSL:  r = (c == 8'd10) ? ST_START : ST_CSL;
      ST_CML:  r = (c == "*") ? ST_CMLE : ST_CML;
      ST_CMLE: r = (c == "/") ? ST_START : ST_CML;
      ST_DOLLAR: r = is_alnum(c) ? ST_VAR : ST_FAIL;
      ST_VAR, ST_IDENT: r = (is_alnum(c) || c == "_") ? s : ST_FAIL;
      ST_EXCL:   r = (c == "=") ? ST_NE0 : ST_FAIL;
      ST_NE0:    r = (c == "=") ? ST_NE1 : ST_FAIL;
      ST_ASSIGN: r = (c == "=") ? ST_EQ0 : ST_FAIL;
      ST_EQ0:    r = (c == "=") ? ST_EQ1 : ST_FAIL;
      ST_GT:     r = (c == "=") ? ST_GE : ST_FAIL;
      ST_LT: begin
        if (c == "?") r = ST_TAG0;
        else if (c == "=") r = ST_LE;
      end
      ST_STR0: begin
        if (is_quote(c)) r = ST_STR1;
        else if (c == "\\") r = ST_ESC0;
        else if (is_strch(c)) r = ST_STR0;
      end
      ST_ESC0: begin
        if (c inside {"\\", "\"", "n", "t", "$", 8'd39}) r = ST_ESC1;
        else if (c == "x") r = ST_HEX0;
        else if (c inside {["0":"3"]}) r = ST_OCT;
        else r = ST_STR0;
      end
      ST_ESC1: begin
        if (is_quote(c)) r = ST_STR1;
        else if (is_strch(c)) r = ST_STR0;
      end
      ST_OCT: begin
        if (is_quote(c)) r = ST_STR1;
        else if (c inside {["0":"7"]}) r = ST_OCT;
      end
      ST_HEX0: begin
        if (is_quote(c)) r = ST_STR1;
        else if (is_alnum(c)) r = ST_HEX1;
      end
      ST_HEX1: begin
        if (is_quote(c)) r = ST_STR1;
        else if (is_alnum(c)) r = ST_HEX2;
      end
      ST_HEX2: begin
        if (is_quote(c)) r = ST_STR1;
        else if ((c > 8'd31) && (c != "$")) r = ST_STR0;
      end
      ST_TAG0: r = (c == "p") ? ST_TAG1 : ST_FAIL;
      ST_TAG1: r = (c == "h") ? ST_TAG2 : ST_FAIL;
      ST_TAG2: r = (c == "p") ? ST_TAG3 : ST_FAIL;
      ST_TAG3: r = is_space(c) ? ST_TAG4 : ST_FAIL;
      default: r = ST_FAIL;
    endcase
    return r;
  endfunction

  function automatic token_kind_e kind_of(scan_state_e s);
    token_kind_e k;
    case (s)
      ST_DOT:    k = KIND_DOT;
      ST_DDOT:   k = KIND_COLON;
      ST_LBR:    k = KIND_LPAREN;
      ST_RBR:    k = KIND_RPAREN;
      ST_LCB:    k = KIND_LBRACE;
      ST_RCB:    k = KIND_RBRACE;
      ST_SEMI:   k = KIND_SEMI;
      ST_PLUS:   k = KIND_PLUS;
      ST_COMMA:  k = KIND_COMMA;
      ST_MUL:    k = KIND_MUL;
      ST_MINUS:  k = KIND_MINUS;
      ST_NUM:    k = KIND_INT;
      ST_DEC1:   k = KIND_DECIMAL;
      ST_EXP1:   k = KIND_EXPONENT;
      ST_DIV:    k = KIND_DIV;
      ST_QMARK:  k = KIND_QMARK;
      ST_TAGEND: k = KIND_CLOSE_TAG;
      ST_VAR:    k = KIND_VAR;
      ST_NE1:    k = KIND_NE;
      ST_EQ1:    k = KIND_EQ;
      ST_IDENT:  k = KIND_IDENT;
      ST_GT:     k = KIND_GT;
      ST_GE:     k = KIND_GE;
      ST_LT:     k = KIND_LT;
      ST_ASSIGN: k = KIND_ASSIGN;
      ST_LE:     k = KIND_LE;
      ST_TAG4:   k = KIND_OPEN_TAG;
      ST_STR1:   k = KIND_STRING;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

FILE: src/sltc_step.sv
// one scanner step: next state, next length count and up to two tokens for one byte
`timescale 1ns / 1ps

module sltc_step #(
  parameter int unsigned MAX_LEXEME = 4095
) (
  input  sltc_pkg::scan_state_e                   state_i,
  input  logic [$clog2(MAX_LEXEME+1)-1:0]         count_i,
  input  logic [7:0]                              char_code_i,
  input  logic                                    end_mark_i,
  output sltc_pkg::scan_state_e                   state_o,
  output logic [$clog2(MAX_LEXEME+1)-1:0]         count_o,
  output logic [1:0]                              tok_num_o,
  output sltc_pkg::token_t                        tok0_o,
  output sltc_pkg::token_t                        tok1_o
);
  import sltc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LEXEME + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LEXEME);

  scan_state_e        first_nxt;
  scan_state_e        retry_nxt;
  scan_state_e        base_state;
  logic               cut;
  logic               fail;
  logic [CntW-1:0]    base_count;
  logic [CntW-1:0]    bumped;
  token_t             cut_tok;
  token_t             err_tok;

  always_comb begin
    first_nxt  = advance(state_i, char_code_i);
    cut        = (first_nxt == ST_FAIL) && (state_i != ST_START);
    retry_nxt  = cut ? advance(ST_START, char_code_i) : first_nxt;
    fail       = (retry_nxt == ST_FAIL);
    base_state = cut ? ST_START : state_i;
    base_count = cut ? '0 : count_i;

    // comment bodies do not add to the length
    if (base_state inside {ST_CSL, ST_CML, ST_CMLE}) begin
      bumped = base_count;
    end else if (base_count < CntMax) begin
      bumped = base_count + CntW'(1);
    end else begin
      bumped = CntMax;
    end

    cut_tok.kind = kind_of(state_i);
    cut_tok.len  = LenW'(count_i);
    cut_tok.last = ~fail;
    err_tok.kind = KIND_ERROR;
    err_tok.len  = LenW'(1);
    err_tok.last = 1'b1;

    tok1_o = err_tok;
    if (end_mark_i) begin
      state_o      = ST_START;
      count_o      = '0;
      tok_num_o    = 2'd1;
      tok0_o.kind  = (state_i == ST_START) ? KIND_END : kind_of(state_i);
      tok0_o.len   = (state_i == ST_START) ? '0 : LenW'(count_i);
      tok0_o.last  = 1'b1;
    end else begin
      if (fail) begin
        state_o = ST_START;
        count_o = '0;
      end else begin
        state_o = retry_nxt;
        count_o = (retry_nxt == ST_START) ? '0 : bumped;
      end
      tok_num_o = {1'b0, cut} + {1'b0, fail};
      tok0_o    = cut ? cut_tok : err_tok;
    end
  end

endmodule

FILE: src/script_lexer_token_classifier.sv
// top level of the script lexer token classifier: input stage, scanner state, token queue
//
// usage
//   s_axis carries one source byte per transaction in tdata, or an end-of-input
//   mark in tuser. m_axis carries the tokens: kind and lexeme length in tdata,
//   tlast marks the final token caused by one input transaction.
//   a byte that ends the pending token and cannot start a new one gives two
//   tokens; whitespace between tokens, comment bytes and bytes that extend a token give none.
// flow
//   a byte accepted into the input stage is scanned once the token queue has
//   room; its tokens are registered in the queue and then shown on m_axis.
//   one byte per cycle is sustained while m_axis takes tokens; a byte that
//   gives two tokens stalls the next byte, set by the three-entry token queue
//   that takes a new byte only while it holds at most one token.
// reset
//   the scanner returns to the start state with a zero length count and the
//   input stage and token queue are emptied.
// stall
//   while m_axis is stalled the queue fills and s_axis tready drops; nothing
//   is lost and scanning resumes once tokens are taken.
`timescale 1ns / 1ps

module script_lexer_token_classifier #(
  parameter int unsigned MAX_LEXEME = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tuser_i,   // [0] end_mark
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [4:0] token_kind, [16:5] lexeme_length, zero pad
  output logic        m_axis_tlast_o    // last_of_run
);
  import sltc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LEXEME + 1);
  localparam int unsigned QDepth = 3;

  // input stage
  logic             in_vld_q;
  logic [7:0]       in_char_q;
  logic             in_end_q;
  logic             fire;
  logic             in_take;

  // scanner state
  scan_state_e      state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;

  // token queue, slot 0 is the head
  token_t           slot_q [QDepth];
  token_t           slot_d [QDepth];
  logic [1:0]       qcnt_q, qcnt_d;
  logic [1:0]       qcnt_pop;
  logic             pop;
  logic             push;

  logic [1:0]       tok_num;
  token_t           tok0;
  token_t           tok1;

  assign fire            = in_vld_q && (qcnt_q <= 2'd1);
  assign s_axis_tready_o = ~in_vld_q || fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tuser_i;
    end
  end

  sltc_step #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_step (
    .state_i     (state_q),
    .count_i     (count_q),
    .char_code_i (in_char_q),
    .end_mark_i  (in_end_q),
    .state_o     (state_d),
    .count_o     (count_d),
    .tok_num_o   (tok_num),
    .tok0_o      (tok0),
    .tok1_o      (tok1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      count_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign pop  = m_axis_tvalid_o && m_axis_tready_i;
  assign push = fire && (tok_num != 2'd0);

  always_comb begin
    qcnt_pop  = qcnt_q - {1'b0, pop};
    slot_d[0] = pop ? slot_q[1] : slot_q[0];
    slot_d[1] = pop ? slot_q[2] : slot_q[1];
    slot_d[2] = slot_q[2];
    for (int i = 0; i < QDepth; i++) begin
      if (push && (2'(i) == qcnt_pop)) begin
        slot_d[i] = tok0;
      end else if (push && (tok_num == 2'd2) && (2'(i) == qcnt_pop + 2'd1)) begin
        slot_d[i] = tok1;
      end
    end
    qcnt_d = qcnt_pop + (fire ? tok_num : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else begin
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign m_axis_tvalid_o = (qcnt_q != 2'd0);
  assign m_axis_tdata_o  = {7'd0, slot_q[0].len, slot_q[0].kind};
  assign m_axis_tlast_o  = slot_q[0].last;

  // assertions
  a_start_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> (count_q == '0))
    else $error("start state with nonzero length count");

  a_no_fail_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_FAIL)
    else $error("scanner holds the fail state");

  a_count_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_LEXEME))
    else $error("length count beyond saturation");

  a_end_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_end_q) |=> (state_q == ST_START && count_q == '0))
    else $error("end of input did not return scanner to start");

  a_queue_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= 2'(QDepth))
    else $error("token queue overflow");

endmodule

FILE: tb/sv/sltc_token_check.sv
// checker for the token classifier: predicts tokens from accepted bytes and compares them
`timescale 1ns / 1ps

module sltc_token_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import sltc_pkg::*;

  localparam int unsigned LexemeMax = 4095;

  scan_state_e     lex_state = ST_START;
  logic [LenW-1:0] lex_count = '0;
  token_t          pending_tokens [$];
  int unsigned     mismatches = 0;
  token_t          want;
  logic [4:0]      got_kind;
  logic [LenW-1:0] got_len;

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_letter(c) || is_num(c);
  endfunction

  function automatic logic is_quote_char(logic [7:0] c);
    return (c == "\"") || (c == 8'd39);
  endfunction

  function automatic logic is_text_char(logic [7:0] c);
    return ((c > 8'd31) && (c != "$")) || is_ws(c);
  endfunction

  // transition of the lexer automaton, ST_FAIL when the byte cannot extend
  function automatic scan_state_e lex_next(scan_state_e s, logic [7:0] c);
    scan_state_e r;
    r = ST_FAIL;
    case (s)
      ST_START: begin
        if (is_ws(c)) r = ST_START;
        else if (is_letter(c)) r = ST_IDENT;
        else if (is_num(c)) r = ST_NUM;
        else if (is_quote_char(c)) r = ST_STR0;
        else if (c == "-") r = ST_MINUS;
        else if (c == "*") r = ST_MUL;
        else if (c == ",") r = ST_COMMA;
        else if (c == "+") r = ST_PLUS;
        else if (c == ";") r = ST_SEMI;
        else if (c == "}") r = ST_RCB;
        else if (c == "{") r = ST_LCB;
        else if (c == ")") r = ST_RBR;
        else if (c == "(") r = ST_LBR;
        else if (c == ".") r = ST_DOT;
        else if (c == "/") r = ST_DIV;
        else if (c == "?") r = ST_QMARK;
        else if (c == "$") r = ST_DOLLAR;
        else if (c == "!") r = ST_EXCL;
        else if (c == "=") r = ST_ASSIGN;
        else if (c == ">") r = ST_GT;
        else if (c == ":") r = ST_DDOT;
        else if (c == "<") r = ST_LT;
      end
      ST_QMARK: if (c == ">") r = ST_TAGEND;
      ST_NUM: begin
        if (is_num(c)) r = ST_NUM;
        else if (c == ".") r = ST_DEC0;
        else if ((c == "e") || (c == "E")) r = ST_EXP0;
      end
      ST_EXP0, ST_EXP1: if (is_num(c)) r = ST_EXP1;
      ST_DEC0: if (is_num(c)) r = ST_DEC1;
      ST_DEC1: begin
        if (is_num(c)) r = ST_DEC1;
        else if ((c == "e") || (c == "E")) r = ST_EXP0;
      end
      ST_DIV: begin
        if (c == "/") r = ST_CSL;
        else if (c == "*") r = ST_CML;
      end
      ST_CSL: r = (c == 8'd10) ? ST_START : ST_CSL;
      ST_CML: r = (c == "*") ? ST_CMLE : ST_CML;
      ST_CMLE: r = (c == "/") ? ST_START : ST_CML;
      ST_DOLLAR: if (is_word(c)) r = ST_VAR;
      ST_VAR, ST_IDENT: if (is_word(c) || (c == "_")) r = s;
      ST_EXCL: if (c == "=") r = ST_NE0;
      ST_NE0: if (c == "=") r = ST_NE1;
      ST_ASSIGN: if (c == "=") r = ST_EQ0;
      ST_EQ0: if (c == "=") r = ST_EQ1;
      ST_GT: if (c == "=") r = ST_GE;
      ST_LT: begin
        if (c == "?") r = ST_TAG0;
        else if (c == "=") r = ST_LE;
      end
      ST_STR0: begin
        if (is_quote_char(c)) r = ST_STR1;
        else if (c == "\\") r = ST_ESC0;
        else if (is_text_char(c)) r = ST_STR0;
      end
      ST_ESC0: begin
        if ((c == "\\") || (c == "\"") || (c == "n") || (c == "t") || (c == "$") ||
            (c == 8'd39)) r = ST_ESC1;
        else if (c == "x") r = ST_HEX0;
        else if ((c >= "0") && (c <= "3")) r = ST_OCT;
        else r = ST_STR0;
      end
      ST_ESC1: begin
        if (is_quote_char(c)) r = ST_STR1;
        else if (is_text_char(c)) r = ST_STR0;
      end
      ST_OCT: begin
        if (is_quote_char(c)) r = ST_STR1;
        else if ((c >= "0") && (c <= "7")) r = ST_OCT;
      end
      ST_HEX0: begin
        if (is_quote_char(c)) r = ST_STR1;
        else if (is_word(c)) r = ST_HEX1;
      end
      ST_HEX1: begin
        if (is_quote_char(c)) r = ST_STR1;
        else if (is_word(c)) r = ST_HEX2;
      end
      ST_HEX2: begin
        if (is_quote_char(c)) r = ST_STR1;
        else if ((c > 8'd31) && (c != "$")) r = ST_STR0;
      end
      ST_TAG0: if (c == "p") r = ST_TAG1;
      ST_TAG1: if (c == "h") r = ST_TAG2;
      ST_TAG2: if (c == "p") r = ST_TAG3;
      ST_TAG3: if (is_ws(c)) r = ST_TAG4;
      default: r = ST_FAIL;
    endcase
    return r;
  endfunction

  function automatic token_kind_e state_kind(scan_state_e s);
    token_kind_e k;
    case (s)
      ST_DOT:    k = KIND_DOT;
      ST_DDOT:   k = KIND_COLON;
      ST_LBR:    k = KIND_LPAREN;
      ST_RBR:    k = KIND_RPAREN;
      ST_LCB:    k = KIND_LBRACE;
      ST_RCB:    k = KIND_RBRACE;
      ST_SEMI:   k = KIND_SEMI;
      ST_PLUS:   k = KIND_PLUS;
      ST_COMMA:  k = KIND_COMMA;
      ST_MUL:    k = KIND_MUL;
      ST_MINUS:  k = KIND_MINUS;
      ST_NUM:    k = KIND_INT;
      ST_DEC1:   k = KIND_DECIMAL;
      ST_EXP1:   k = KIND_EXPONENT;
      ST_DIV:    k = KIND_DIV;
      ST_QMARK:  k = KIND_QMARK;
      ST_TAGEND: k = KIND_CLOSE_TAG;
      ST_VAR:    k = KIND_VAR;
      ST_NE1:    k = KIND_NE;
      ST_EQ1:    k = KIND_EQ;
      ST_IDENT:  k = KIND_IDENT;
      ST_GT:     k = KIND_GT;
      ST_GE:     k = KIND_GE;
      ST_LT:     k = KIND_LT;
      ST_ASSIGN: k = KIND_ASSIGN;
      ST_LE:     k = KIND_LE;
      ST_TAG4:   k = KIND_OPEN_TAG;
      ST_STR1:   k = KIND_STRING;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  task automatic scan_char(input logic [7:0] c, input logic end_mark);
    token_t      found [2];
    int          n;
    scan_state_e nxt;
    n = 0;
    if (end_mark) begin
      found[0].kind = (lex_state == ST_START) ? KIND_END : state_kind(lex_state);
      found[0].len = (lex_state == ST_START) ? '0 : lex_count;
      n = 1;
      lex_state = ST_START;
      lex_count = '0;
    end else begin
      nxt = lex_next(lex_state, c);
      // the byte cuts the pending token and is handled again from the start state
      if ((nxt == ST_FAIL) && (lex_state != ST_START)) begin
        found[n].kind = state_kind(lex_state);
        found[n].len = lex_count;
        n++;
        lex_state = ST_START;
        lex_count = '0;
        nxt = lex_next(ST_START, c);
      end
      if (nxt == ST_FAIL) begin
        found[n].kind = KIND_ERROR;
        found[n].len = LenW'(1);
        n++;
        lex_state = ST_START;
        lex_count = '0;
      end else begin
        // comment bytes do not count
        if (!(lex_state inside {ST_CSL, ST_CML, ST_CMLE}) && (lex_count < LexemeMax))
          lex_count++;
        if (nxt == ST_START) lex_count = '0;
        lex_state = nxt;
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_tokens.push_back(found[i]);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lex_state = ST_START;
      lex_count = '0;
    end else begin
      if (s_tvalid_i && s_tready_i) scan_char(s_tdata_i, s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        got_kind = m_tdata_i[4:0];
        got_len = m_tdata_i[16:5];
        if (pending_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected token kind %0d len %0d last %0b",
                     $time, got_kind, got_len, m_tlast_i);
        end else begin
          want = pending_tokens.pop_front();
          if ((got_kind !== want.kind) || (got_len !== want.len) ||
              (m_tlast_i !== want.last)) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: token mismatch, expected kind %0d len %0d last %0b,",
                        " got kind %0d len %0d last %0b"},
                       $time, want.kind, want.len, want.last,
                       got_kind, got_len, m_tlast_i);
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o <= pending_tokens.size();
  end

endmodule

FILE: tb/sv/tb_script_lexer_token_classifier.sv
// testbench top for the token classifier: clock, reset, byte stream stimulus and verdict
`timescale 1ns / 1ps

module tb_script_lexer_token_classifier;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 450;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'd0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic        m_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned sent;

  // bit 8 marks end of input, bits 7:0 the source byte
  logic [8:0]  src_bytes [$];

  string op_text [24] = '{"!==", "===", "==", "!", "!=", "<=", "<", ">=", ">", "=", "?>",
                          "?", "+", "-", "*", ",", ";", "{", "}", "(", ")", ".", ":", "/"};
  string esc_text = "\\\"nt$'qz";

  script_lexer_token_classifier i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  sltc_token_check i_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tlast_i    (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    m_ready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_script_lexer_token_classifier failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      default: return rand_digit();
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    int unsigned r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'd32 : 8'(r);
  endfunction

  task automatic queue_char(input logic [7:0] c);
    src_bytes.push_back({1'b0, c});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic queue_end();
    src_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  // one lexical fragment, mostly well formed, sometimes noise or end of input
  task automatic queue_fragment();
    logic [7:0] c;
    logic [7:0] q;
    case ($urandom_range(0, 14))
      0: begin
        queue_char(8'("a" + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 6)) queue_char(($urandom_range(0, 5) == 0) ? "_" : rand_alnum());
      end
      1: begin
        queue_char("$");
        queue_char(rand_alnum());
        repeat ($urandom_range(0, 5)) queue_char(($urandom_range(0, 5) == 0) ? "_" : rand_alnum());
      end
      2: repeat ($urandom_range(1, 5)) queue_char(rand_digit());
      3: begin
        repeat ($urandom_range(1, 3)) queue_char(rand_digit());
        queue_char(".");
        repeat ($urandom_range(1, 3)) queue_char(rand_digit());
        if ($urandom_range(0, 2) == 0) begin
          queue_char($urandom_range(0, 1) ? "e" : "E");
          repeat ($urandom_range(1, 2)) queue_char(rand_digit());
        end
      end
      4: begin
        repeat ($urandom_range(1, 3)) queue_char(rand_digit());
        queue_char($urandom_range(0, 1) ? "e" : "E");
        repeat ($urandom_range(1, 3)) queue_char(rand_digit());
      end
      5: begin
        q = $urandom_range(0, 1) ? "\"" : 8'd39;
        queue_char(q);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0: begin
              c = 8'($urandom_range(32, 126));
              if ((c == "$") || (c == "\\") || (c == "\"") || (c == 8'd39)) c = "w";
              queue_char(c);
            end
            1: queue_char(8'($urandom_range(128, 255)));
            2: queue_char(rand_space());
            default: begin
              queue_char("\\");
              case ($urandom_range(0, 2))
                0: queue_char(esc_text[$urandom_range(0, 7)]);
                1: begin
                  queue_char("x");
                  repeat ($urandom_range(0, 2)) queue_char(rand_alnum());
                end
                default: begin
                  queue_char(8'("0" + $urandom_range(0, 3)));
                  repeat ($urandom_range(0, 2)) queue_char(8'("0" + $urandom_range(0, 7)));
                end
              endcase
            end
          endcase
        end
        queue_char($urandom_range(0, 1) ? "\"" : 8'd39);
      end
      6: queue_text(op_text[$urandom_range(0, 23)]);
      7: begin
        queue_text(($urandom_range(0, 3) == 0) ? "<?ph" : "<?php");
        queue_char(rand_space());
      end
      8: begin
        queue_text("//");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          queue_char((c == 8'd10) ? "c" : c);
        end
        queue_char(8'd10);
      end
      9: begin
        queue_text("/*");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          queue_char((c == "*") ? "c" : c);
        end
        queue_text("*/");
      end
      10, 11, 12: repeat ($urandom_range(1, 2)) queue_char(rand_space());
      13: queue_char(8'($urandom_range(0, 255)));
      default: queue_end();
    endcase
  endtask

  task automatic drive_char(input logic [7:0] c, input logic eom);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk);
    end
    s_valid = 1'b1;
    s_data = c;
    s_user = eom;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_queued();
    logic [8:0] item;
    while (src_bytes.size() > 0) begin
      item = src_bytes.pop_front();
      drive_char(item[7:0], item[8]);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 69 : 0;
      snk_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 29 : 0;
      if (ph == 0) begin
        // end with nothing pending, illegal bytes, open tag, cut token, unfinished
        // operator, comment, exponent and close tag
        queue_end();
        queue_char(8'h00);
        queue_text("<?php ");
        queue_text("a");
        queue_char(8'hff);
        queue_text("==");
        queue_end();
        queue_text("/*x*/");
        queue_text("1e9");
        queue_text("?>");
        queue_end();
        send_queued();
      end
      sent = 0;
      while (sent < PhaseItems) begin
        queue_fragment();
        sent += src_bytes.size();
        send_queued();
      end
    end
    s_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_script_lexer_token_classifier passed");
    end else begin
      $display("tb_script_lexer_token_classifier failed");
    end
    $finish;
  end

endmodule
